// File: hdl/kdslp_pkg.sv
// Shared constants for the key debounce block with short and long press detection.
`default_nettype none
package kdslp_pkg;
    localparam int unsigned COUNTER_WIDTH_DEF = 16;

    localparam logic [15:0] DEBOUNCE_RESET = 16'd30;
    localparam logic [15:0] PERIOD_RESET   = 16'd100;
    localparam logic [3:0]  SHORT_RESET    = 4'd5;
    localparam logic [3:0]  CAP_RESET      = 4'd12;

    // Configuration register indexes.
    localparam logic [1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [1:0] REG_PERIOD   = 2'd1;
    localparam logic [1:0] REG_SHORT    = 2'd2;
    localparam logic [1:0] REG_CAP      = 2'd3;

    // Phase codes.
    localparam logic [1:0] PH_IDLE     = 2'd0;
    localparam logic [1:0] PH_DEBOUNCE = 2'd1;
    localparam logic [1:0] PH_HOLD     = 2'd2;
    localparam logic [1:0] PH_WAIT_REL = 2'd3;

    // Key indexes and event codes.
    localparam logic [2:0] KEYIDX_TOP_L  = 3'd4;
    localparam logic [2:0] KEYIDX_TOP_R  = 3'd5;
    localparam logic [2:0] EV_LT_SHORT   = 3'd4;
    localparam logic [2:0] EV_LT_LONG    = 3'd5;
    localparam logic [2:0] EV_RT_SHORT   = 3'd6;
    localparam logic [2:0] EV_RT_LONG    = 3'd7;

    localparam logic [5:0] ALL_RELEASED = 6'h3F;
endpackage
`default_nettype wire

// File: hdl/key_debounce_short_long_press.sv
// Top level of the key debounce block with short and long press detection.
//
// Usage: each input transaction on i_in_valid / o_in_stall is one tick carrying the six
// active-low key levels (left, right, up, down, left top, right top). After any key
// reads low the block waits the debounce time, picks the first pressed key in that
// priority order and reports it. Direction keys are reported on release; the two top
// keys are timed in periods and reported as a short or a long press.
// Results leave on o_out_valid / i_out_stall as o_key_event, at most one per tick.
// A result from a tick is registered into the output register, or into the skid register while the receiver stalls.
// Throughput: one tick per cycle while o_in_stall is low; the state update is a single
// decrement and compare between the state registers.
// The output register is backed by a one-entry skid register: while the receiver
// stalls, ticks keep being accepted until a second result has to be held, and only then
// is o_in_stall raised, and it drops as soon as the held result moves on.
// Configuration writes (i_cfg_valid, o_cfg_ready tied high) are taken at any edge; they
// belong in gaps where no tick is in flight and no result is still owed.
// Reset (synchronous, active low) returns to the idle phase, empties both result
// registers and loads the default register values.
`default_nettype none
module key_debounce_short_long_press #(
    parameter int unsigned COUNTER_WIDTH = kdslp_pkg::COUNTER_WIDTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [5:0]  i_key_levels,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [2:0]       o_key_event,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);
    localparam int unsigned CW = COUNTER_WIDTH;
    localparam logic [32:0] CntMax = (33'd1 << CW) - 33'd1;

    // Configuration registers.
    logic [15:0] r_debounce;
    logic [15:0] r_period;
    logic [3:0]  r_short_max;
    logic [3:0]  r_cap;

    // Block state.
    logic [1:0]    r_phase,  n_phase;
    logic [CW-1:0] r_ticks,  n_ticks;
    logic [3:0]    r_periods, n_periods;
    logic [2:0]    r_key,    n_key;

    // Result path: output register and skid register.
    logic       r_out_valid;
    logic [2:0] r_out_event;
    logic       r_skid_valid;
    logic [2:0] r_skid_event;

    logic       w_accept;
    logic       w_emit;
    logic [2:0] w_event;
    logic       w_out_free;

    logic [CW-1:0] w_debounce_load;
    logic [CW-1:0] w_period_load;
    logic [15:0]   w_period_min;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_skid_valid;
    assign w_accept    = i_in_valid && !r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_key_event = r_out_event;
    assign w_out_free  = !r_out_valid || !i_out_stall;

    // Loads into the tick counter saturate at the counter's largest value.
    assign w_period_min    = (r_period == 16'd0) ? 16'd1 : r_period;
    assign w_debounce_load = ({17'd0, r_debounce} > CntMax) ? CntMax[CW-1:0]
                                                             : CW'(r_debounce);
    assign w_period_load   = ({17'd0, w_period_min} > CntMax) ? CntMax[CW-1:0]
                                                               : CW'(w_period_min);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce  <= kdslp_pkg::DEBOUNCE_RESET;
            r_period    <= kdslp_pkg::PERIOD_RESET;
            r_short_max <= kdslp_pkg::SHORT_RESET;
            r_cap       <= kdslp_pkg::CAP_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                kdslp_pkg::REG_DEBOUNCE: r_debounce  <= i_cfg_data;
                kdslp_pkg::REG_PERIOD:   r_period    <= i_cfg_data;
                kdslp_pkg::REG_SHORT:    r_short_max <= i_cfg_data[3:0];
                kdslp_pkg::REG_CAP:      r_cap       <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // One tick of the press tracking. choose and finish are the two shared decisions
    // (key choice after debounce, end of hold timing for a top key).
    always_comb begin
        logic [CW-1:0] dec;
        logic          zero;
        logic          any_low;
        logic [2:0]    pick;
        logic          do_choose;
        logic          do_finish;
        logic [3:0]    fin_periods;
        logic [2:0]    fin_key;
        logic          fin_low;

        n_phase   = r_phase;
        n_ticks   = r_ticks;
        n_periods = r_periods;
        n_key     = r_key;
        w_emit    = 1'b0;
        w_event   = r_key;
        do_choose = 1'b0;
        do_finish = 1'b0;
        fin_periods = r_periods;
        fin_key     = r_key;
        fin_low     = 1'b0;

        dec  = (r_ticks != '0) ? r_ticks - CW'(1) : r_ticks;
        zero = (dec == '0);

        any_low = (i_key_levels != kdslp_pkg::ALL_RELEASED);
        pick    = 3'd0;
        for (int k = 5; k >= 0; k--) begin
            if (!i_key_levels[k]) begin
                pick = 3'(k);
            end
        end

        unique case (r_phase)
            kdslp_pkg::PH_DEBOUNCE: begin
                n_ticks = dec;
                if (zero) begin
                    do_choose = 1'b1;
                end
            end
            kdslp_pkg::PH_HOLD: begin
                n_ticks = dec;
                if (zero) begin
                    if (i_key_levels[r_key] || (r_periods >= r_cap)) begin
                        do_finish = 1'b1;
                    end else begin
                        n_periods = r_periods + 4'd1;
                        n_ticks   = w_period_load;
                    end
                end
            end
            kdslp_pkg::PH_WAIT_REL: begin
                if (i_key_levels[r_key]) begin
                    w_emit  = 1'b1;
                    n_phase = kdslp_pkg::PH_IDLE;
                    if (r_key == kdslp_pkg::KEYIDX_TOP_L) begin
                        w_event = kdslp_pkg::EV_LT_LONG;
                    end else if (r_key == kdslp_pkg::KEYIDX_TOP_R) begin
                        w_event = kdslp_pkg::EV_RT_LONG;
                    end else begin
                        w_event = r_key;
                    end
                end
            end
            default: begin
                if (any_low) begin
                    n_ticks = w_debounce_load;
                    if (w_debounce_load == '0) begin
                        do_choose = 1'b1;
                    end else begin
                        n_phase = kdslp_pkg::PH_DEBOUNCE;
                    end
                end
            end
        endcase

        if (do_choose) begin
            if (!any_low) begin
                n_phase = kdslp_pkg::PH_IDLE;
            end else begin
                n_key   = pick;
                fin_key = pick;
                if (pick < kdslp_pkg::KEYIDX_TOP_L) begin
                    n_phase = kdslp_pkg::PH_WAIT_REL;
                end else if (r_cap == 4'd0) begin
                    n_periods   = 4'd0;
                    fin_periods = 4'd0;
                    do_finish   = 1'b1;
                end else begin
                    n_periods = 4'd1;
                    n_ticks   = w_period_load;
                    n_phase   = kdslp_pkg::PH_HOLD;
                end
            end
        end

        if (do_finish) begin
            fin_low = !i_key_levels[fin_key];
            if (fin_periods <= r_short_max) begin
                w_emit  = 1'b1;
                n_phase = kdslp_pkg::PH_IDLE;
                w_event = (fin_key == kdslp_pkg::KEYIDX_TOP_R) ? kdslp_pkg::EV_RT_SHORT
                                                                : kdslp_pkg::EV_LT_SHORT;
            end else if (!fin_low) begin
                w_emit  = 1'b1;
                n_phase = kdslp_pkg::PH_IDLE;
                w_event = (fin_key == kdslp_pkg::KEYIDX_TOP_R) ? kdslp_pkg::EV_RT_LONG
                                                                : kdslp_pkg::EV_LT_LONG;
            end else begin
                n_phase = kdslp_pkg::PH_WAIT_REL;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= kdslp_pkg::PH_IDLE;
            r_ticks   <= '0;
            r_periods <= 4'd0;
            r_key     <= 3'd0;
        end else if (w_accept) begin
            r_phase   <= n_phase;
            r_ticks   <= n_ticks;
            r_periods <= n_periods;
            r_key     <= n_key;
        end
    end

    // Result registers: the skid entry always drains first, so order is kept.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= w_accept && w_emit;
            end
        end else if (w_accept && w_emit) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            r_out_event <= r_skid_valid ? r_skid_event : w_event;
        end else if (w_accept && w_emit) begin
            r_skid_event <= w_event;
        end
    end

    // The skid register is only ever filled behind a full output register.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds a result while the output register is empty");

    // A result produced against a stalled output must land in the skid register.
    a_stalled_result_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_emit && r_out_valid && i_out_stall) |=> r_skid_valid)
        else $error("result lost while the output was stalled");

    // Hold timing only ever runs for one of the two top keys.
    a_hold_top_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == kdslp_pkg::PH_HOLD) |->
            (r_key == kdslp_pkg::KEYIDX_TOP_L || r_key == kdslp_pkg::KEYIDX_TOP_R))
        else $error("hold timing entered for a direction key");

    // While waiting for release the chosen key is always a real key.
    a_wait_key_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == kdslp_pkg::PH_WAIT_REL) |-> (r_key <= kdslp_pkg::KEYIDX_TOP_R))
        else $error("waiting for release of a key that does not exist");
endmodule
`default_nettype wire
